[rtl/huffman_code_bit_packer_assert.svh]
// Assertion macros for the bit packer checker.
`ifndef HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH

// same-cycle implication
`define HCBP_ASSERT_SAME(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("hcbp assertion failed");

// next-cycle implication
`define HCBP_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("hcbp assertion failed");

`endif

[rtl/hcbp_pkg.sv]
// Shared types and constants of the Huffman code bit packer.
package hcbp_pkg;

    localparam int MAX_CODE_LEN_DEF = 24;
    localparam int NUM_SYMBOLS_DEF  = 256;
    localparam int STORE_CODE_WIDTH = 24;
    localparam int BYTE_BITS        = 8;
    localparam int REQ_W            = 2;
    localparam int SYM_W            = 8;
    localparam int LEN_W            = 5;
    localparam int PAD_W            = 3;
    localparam int PEND_W           = 7;
    localparam int RUN_BYTES        = 3;
    localparam int RUN_W            = RUN_BYTES * BYTE_BITS;
    localparam int RUN_IDX_W        = 2;
    localparam int ACC_W            = PEND_W + STORE_CODE_WIDTH;
    localparam int ENTRY_W          = STORE_CODE_WIDTH + LEN_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD   = 2'd0,
        REQ_ENCODE = 2'd1,
        REQ_FLUSH  = 2'd2
    } req_t;

    // lookup stage control
    typedef struct packed {
        logic valid;
        logic flush;
    } s1_t;

    // one run of results handed to the output stage
    typedef struct packed {
        logic                 push;
        logic [RUN_W-1:0]     bytes;
        logic [RUN_IDX_W-1:0] last_idx;
        logic                 flush;
        logic [PAD_W-1:0]     pad;
        logic                 bvalid;
    } run_t;

endpackage

[rtl/hcbp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/hcbp_table.sv]
// Code table: entry valid flags, code RAM and the lookup stage register.
module hcbp_table #(
    parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
    parameter int NUM_SYMBOLS  = hcbp_pkg::NUM_SYMBOLS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   accept,
    input  logic                                   stage_en,
    input  logic [hcbp_pkg::REQ_W-1:0]             req_type,
    input  logic [hcbp_pkg::SYM_W-1:0]             symbol,
    input  logic [hcbp_pkg::STORE_CODE_WIDTH-1:0]  code_bits,
    input  logic [hcbp_pkg::LEN_W-1:0]             code_len,
    output hcbp_pkg::s1_t                          s1,
    output logic [hcbp_pkg::STORE_CODE_WIDTH-1:0]  rd_code,
    output logic [hcbp_pkg::LEN_W-1:0]             rd_len
);

    localparam int IDX_W   = $clog2(NUM_SYMBOLS);
    localparam int LEN_LIM = (MAX_CODE_LEN < hcbp_pkg::STORE_CODE_WIDTH) ?
                             MAX_CODE_LEN : hcbp_pkg::STORE_CODE_WIDTH;

    logic [NUM_SYMBOLS-1:0]               valid_reg;
    logic [NUM_SYMBOLS-1:0]               valid_next;
    hcbp_pkg::s1_t                        s1_reg;
    hcbp_pkg::s1_t                        s1_next;
    logic                                 in_range;
    logic [IDX_W-1:0]                     idx;
    logic                                 is_load;
    logic                                 is_encode;
    logic                                 is_flush;
    logic                                 hit;
    logic [hcbp_pkg::LEN_W-1:0]           len_sat;
    logic [hcbp_pkg::STORE_CODE_WIDTH-1:0] bits_masked;
    logic [hcbp_pkg::ENTRY_W-1:0]         rdata;

    assign in_range  = {1'b0, symbol} < (hcbp_pkg::SYM_W + 1)'(NUM_SYMBOLS);
    assign idx       = symbol[IDX_W-1:0];
    assign is_load   = req_type == hcbp_pkg::REQ_LOAD;
    assign is_encode = req_type == hcbp_pkg::REQ_ENCODE;
    assign is_flush  = req_type == hcbp_pkg::REQ_FLUSH;
    assign hit       = in_range && valid_reg[idx];
    assign len_sat   = (code_len > hcbp_pkg::LEN_W'(LEN_LIM)) ?
                       hcbp_pkg::LEN_W'(LEN_LIM) : code_len;

    always_comb
    begin
        for (int i = 0; i < hcbp_pkg::STORE_CODE_WIDTH; i++)
        begin
            bits_masked[i] = code_bits[i] && (hcbp_pkg::LEN_W'(i) < len_sat);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept && is_load && in_range)
        begin
            valid_next[idx] = 1'b1;
        end
    end

    always_comb
    begin
        s1_next = s1_reg;
        if (stage_en)
        begin
            s1_next.valid = accept && ((is_encode && hit) || is_flush);
            s1_next.flush = is_flush;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            s1_reg    <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            s1_reg    <= s1_next;
        end
    end

    hcbp_ram #(
        .WIDTH (hcbp_pkg::ENTRY_W),
        .DEPTH (NUM_SYMBOLS)
    ) u_ram (
        .clk   (clk),
        .we    (accept && is_load && in_range),
        .waddr (idx),
        .wdata ({bits_masked, len_sat}),
        .re    (accept && is_encode && hit),
        .raddr (idx),
        .rdata (rdata)
    );

    assign s1      = s1_reg;
    assign rd_code = rdata[hcbp_pkg::ENTRY_W-1:hcbp_pkg::LEN_W];
    assign rd_len  = rdata[hcbp_pkg::LEN_W-1:0];

endmodule

[rtl/hcbp_pack.sv]
// Bit packer: merges a looked-up code with the pending bits and forms a run.
module hcbp_pack (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  hcbp_pkg::s1_t                         s1,
    input  logic [hcbp_pkg::STORE_CODE_WIDTH-1:0] rd_code,
    input  logic [hcbp_pkg::LEN_W-1:0]            rd_len,
    input  logic                                  out_free,
    output logic                                  adv,
    output hcbp_pkg::run_t                        run
);

    logic [hcbp_pkg::PEND_W-1:0] pend_bits_reg;
    logic [hcbp_pkg::PEND_W-1:0] pend_bits_next;
    logic [hcbp_pkg::PAD_W-1:0]  pend_cnt_reg;
    logic [hcbp_pkg::PAD_W-1:0]  pend_cnt_next;
    logic [hcbp_pkg::ACC_W-1:0]  acc;
    logic [hcbp_pkg::LEN_W-1:0]  total;
    logic [hcbp_pkg::RUN_IDX_W-1:0] nbytes;
    logic [hcbp_pkg::PEND_W-1:0] rest;
    logic                        needs_out;
    logic                        has_pend;

    assign acc      = hcbp_pkg::ACC_W'(pend_bits_reg)
                    | (hcbp_pkg::ACC_W'(rd_code) << pend_cnt_reg);
    assign total    = rd_len + {2'b00, pend_cnt_reg};
    assign nbytes   = total[hcbp_pkg::LEN_W-1:hcbp_pkg::PAD_W];
    assign has_pend = pend_cnt_reg != '0;

    always_comb
    begin
        case (nbytes)
            2'd0:    rest = acc[6:0];
            2'd1:    rest = acc[14:8];
            2'd2:    rest = acc[22:16];
            default: rest = acc[30:24];
        endcase
    end

    assign needs_out = s1.flush || (nbytes != '0);
    assign adv       = s1.valid && (!needs_out || out_free);

    always_comb
    begin
        run.push = adv && needs_out;
        if (s1.flush)
        begin
            run.bytes    = hcbp_pkg::RUN_W'(has_pend ? pend_bits_reg : '0);
            run.last_idx = '0;
            run.flush    = 1'b1;
            run.pad      = has_pend ?
                           hcbp_pkg::PAD_W'(hcbp_pkg::BYTE_BITS - int'(pend_cnt_reg)) : '0;
            run.bvalid   = has_pend;
        end
        else
        begin
            run.bytes    = acc[hcbp_pkg::RUN_W-1:0];
            run.last_idx = nbytes - 2'd1;
            run.flush    = 1'b0;
            run.pad      = '0;
            run.bvalid   = 1'b1;
        end
    end

    always_comb
    begin
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        if (adv)
        begin
            if (s1.flush)
            begin
                pend_bits_next = '0;
                pend_cnt_next  = '0;
            end
            else
            begin
                pend_bits_next = rest;
                pend_cnt_next  = total[hcbp_pkg::PAD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
        end
        else
        begin
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
        end
    end

endmodule

[rtl/hcbp_outq.sv]
// Output stage: holds one run of up to three results and drains it in order.
module hcbp_outq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hcbp_pkg::run_t                run,
    output logic                          out_free,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [hcbp_pkg::BYTE_BITS-1:0] out_byte,
    output logic                          byte_valid,
    output logic [hcbp_pkg::PAD_W-1:0]    pad_bits,
    output logic                          stream_end,
    output logic                          run_last
);

    logic                           vld_reg;
    logic                           vld_next;
    logic [hcbp_pkg::RUN_IDX_W-1:0] idx_reg;
    logic [hcbp_pkg::RUN_IDX_W-1:0] idx_next;
    hcbp_pkg::run_t                 hold_reg;
    hcbp_pkg::run_t                 hold_next;
    logic                           take;
    logic                           is_last;

    assign take     = vld_reg && out_ready;
    assign is_last  = idx_reg == hold_reg.last_idx;
    assign out_free = !vld_reg || (take && is_last);

    always_comb
    begin
        vld_next  = vld_reg;
        idx_next  = idx_reg;
        hold_next = hold_reg;
        if (run.push)
        begin
            vld_next  = 1'b1;
            idx_next  = '0;
            hold_next = run;
        end
        else if (take)
        begin
            if (is_last)
            begin
                vld_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    always_comb
    begin
        case (idx_reg)
            2'd0:    out_byte = hold_reg.bytes[7:0];
            2'd1:    out_byte = hold_reg.bytes[15:8];
            default: out_byte = hold_reg.bytes[23:16];
        endcase
    end

    assign out_valid  = vld_reg;
    assign byte_valid = hold_reg.bvalid;
    assign pad_bits   = hold_reg.pad;
    assign stream_end = hold_reg.flush;
    assign run_last   = is_last;

endmodule

[rtl/huffman_code_bit_packer.sv]
// Huffman code bit packer top level.
// Takes one transaction per cycle unless stalled: loads write a table entry,
// encodes look up the symbol in a registered-read code RAM and append its
// bits LSB-first to the byte stream, flushes pad and close the partial byte.
// A result is registered in the lookup stage and again in the output stage.
// The output stage holds one run of up to three bytes and sends one result
// per cycle while out_ready is high; the input stalls behind a run only while
// a following run waits, and loads and encodes that complete no byte never
// wait on the output. Entry valid flags are flip-flops cleared by reset, so
// the table is usable right after reset.
module huffman_code_bit_packer #(
    parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
    parameter int NUM_SYMBOLS  = hcbp_pkg::NUM_SYMBOLS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [hcbp_pkg::REQ_W-1:0]            req_type,
    input  logic [hcbp_pkg::SYM_W-1:0]            symbol,
    input  logic [hcbp_pkg::STORE_CODE_WIDTH-1:0] code_bits,
    input  logic [hcbp_pkg::LEN_W-1:0]            code_len,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [hcbp_pkg::BYTE_BITS-1:0]        out_byte,
    output logic                                  byte_valid,
    output logic [hcbp_pkg::PAD_W-1:0]            pad_bits,
    output logic                                  stream_end,
    output logic                                  run_last
);

    hcbp_pkg::s1_t                         s1;
    hcbp_pkg::run_t                        run;
    logic [hcbp_pkg::STORE_CODE_WIDTH-1:0] rd_code;
    logic [hcbp_pkg::LEN_W-1:0]            rd_len;
    logic                                  adv;
    logic                                  out_free;

    assign in_ready = !s1.valid || adv;

    hcbp_table #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .NUM_SYMBOLS  (NUM_SYMBOLS)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_valid && in_ready),
        .stage_en  (in_ready),
        .req_type  (req_type),
        .symbol    (symbol),
        .code_bits (code_bits),
        .code_len  (code_len),
        .s1        (s1),
        .rd_code   (rd_code),
        .rd_len    (rd_len)
    );

    hcbp_pack u_pack (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1       (s1),
        .rd_code  (rd_code),
        .rd_len   (rd_len),
        .out_free (out_free),
        .adv      (adv),
        .run      (run)
    );

    hcbp_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .run        (run),
        .out_free   (out_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .pad_bits   (pad_bits),
        .stream_end (stream_end),
        .run_last   (run_last)
    );

endmodule

[rtl/hcbp_checker.sv]
// Port-level checker for the Huffman code bit packer, bound to the top level.
`include "huffman_code_bit_packer_assert.svh"

module hcbp_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [hcbp_pkg::BYTE_BITS-1:0] out_byte,
    input logic                           byte_valid,
    input logic [hcbp_pkg::PAD_W-1:0]     pad_bits,
    input logic                           stream_end,
    input logic                           run_last
);

    `HCBP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `HCBP_ASSERT_SAME(a_end_is_last, clk, rst_n, out_valid && stream_end, run_last)
    `HCBP_ASSERT_SAME(a_empty_flush, clk, rst_n, out_valid && !byte_valid,
        stream_end && (out_byte == '0) && (pad_bits == '0))
    `HCBP_ASSERT_SAME(a_data_no_pad, clk, rst_n, out_valid && !stream_end,
        byte_valid && (pad_bits == '0))

endmodule

bind huffman_code_bit_packer hcbp_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .pad_bits   (pad_bits),
    .stream_end (stream_end),
    .run_last   (run_last)
);
